>>> rtl/core/topographic_pixel_correction_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef TOPOGRAPHIC_PIXEL_CORRECTION_DEFINES_SVH
`define TOPOGRAPHIC_PIXEL_CORRECTION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tpc_pkg.sv
`timescale 1ns / 1ps

package tpc_pkg;

	localparam int LUT_BITS = 6;
	localparam int TAB_N = 1 << LUT_BITS;
	localparam int LOG_SH = 15 - LUT_BITS;
	localparam int EXP_SH = 16 - LUT_BITS;

	localparam int Q_BITS = 32;
	localparam int N_W = 58;
	localparam int D_W = 34;
	localparam int CMP_W = D_W + Q_BITS;

	localparam logic [1:0] MODE_CCORR = 2'd1;
	localparam logic [1:0] MODE_MINN = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_SHADOW = 2'd2;
	localparam logic [1:0] ST_SAT = 2'd3;

	typedef enum logic [1:0] {
		REG_MODE = 2'd0,
		REG_COS_ZENITH = 2'd1,
		REG_C_TERM = 2'd2,
		REG_MINNAERT_K = 2'd3
	} tpc_reg_e;

	typedef struct packed {
		logic [15:0] sample_value;
		logic sample_valid;
		logic signed [15:0] cos_illum;
	} tpc_in_t;

	typedef struct packed {
		logic signed [31:0] corrected;
		logic [1:0] status;
	} tpc_out_t;

	typedef struct packed {
		logic [15:0] v;
		logic [14:0] ci;
		logic [1:0] status;
		logic minn;
		logic neg;
	} tpc_side_t;

	typedef struct packed {
		logic [Q_BITS-1:0] q;
		logic ovf;
	} tpc_div_t;

	typedef struct packed {
		logic [30:0] val;
		logic sat;
	} tpc_mres_t;

	typedef logic [TAB_N:0][16:0] log_tab_t;
	typedef logic [TAB_N:0][17:0] exp_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = x_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > x) begin
				b = b >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	function automatic log_tab_t build_log_tab();
		log_tab_t t;
		logic [63:0] y;
		logic [17:0] r;
		for (int i = 0; i < TAB_N; i++) begin
			y = (64'd1 << 30) + (64'(i) << (30 - LUT_BITS));
			r = '0;
			for (int b = 0; b < 17; b++) begin
				y = (y * y) >> 30;
				if (y >= (64'd2 << 30)) begin
					y = y >> 1;
					r = r | (18'd1 << (16 - b));
				end
			end
			t[i] = 17'((r + 18'd1) >> 1);
		end
		t[TAB_N] = 17'd65536;
		return t;
	endfunction

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		logic [63:0] roots [LUT_BITS+1];
		logic [63:0] p;
		roots[0] = 64'd2 << 30;
		for (int i = 1; i <= LUT_BITS; i++) begin
			roots[i] = isqrt64(roots[i-1] << 30);
		end
		for (int i = 0; i < TAB_N; i++) begin
			p = 64'd1 << 30;
			for (int b = 0; b < LUT_BITS; b++) begin
				if (((i >> b) & 1) != 0) begin
					p = (p * roots[LUT_BITS-b] + (64'd1 << 29)) >> 30;
				end
			end
			t[i] = 18'((p + (64'd1 << 13)) >> 14);
		end
		t[TAB_N] = 18'd131072;
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();
	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

>>> rtl/core/tpc_divider.sv
`timescale 1ns / 1ps

module tpc_divider (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input logic [tpc_pkg::N_W-1:0] in_num,
	input logic [tpc_pkg::D_W-1:0] in_den,
	input tpc_pkg::tpc_side_t in_side,
	output logic out_vld,
	output tpc_pkg::tpc_div_t out_res,
	output tpc_pkg::tpc_side_t out_side
);

	localparam int QB = tpc_pkg::Q_BITS;
	localparam int NW = tpc_pkg::N_W;
	localparam int DW = tpc_pkg::D_W;
	localparam int CW = tpc_pkg::CMP_W;
	localparam logic [QB-1:0] Q_ONE = 1;

	logic [QB:0] vld_s;
	logic [NW-1:0] rem_s [0:QB];
	logic [DW-1:0] d_s [0:QB];
	logic [QB-1:0] q_s [0:QB];
	logic ovf_s [0:QB];
	tpc_pkg::tpc_side_t side_s [0:QB];

	logic ovf_in;
	logic [CW-1:0] dsh [1:QB];
	logic take [1:QB];
	logic [NW-1:0] rem_nxt [1:QB];
	logic [QB-1:0] q_nxt [1:QB];

	assign ovf_in = {{(CW-NW){1'b0}}, in_num} >= {in_den, {QB{1'b0}}};

	always_comb begin
		for (int j = 1; j <= QB; j++) begin
			dsh[j] = {{QB{1'b0}}, d_s[j-1]} << (QB - j);
			take[j] = {{(CW-NW){1'b0}}, rem_s[j-1]} >= dsh[j];
			rem_nxt[j] = take[j] ? rem_s[j-1] - dsh[j][NW-1:0] : rem_s[j-1];
			q_nxt[j] = take[j] ? (q_s[j-1] | (Q_ONE << (QB - j))) : q_s[j-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QB-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= in_num;
			d_s[0] <= in_den;
			q_s[0] <= '0;
			ovf_s[0] <= ovf_in;
			side_s[0] <= in_side;
			for (int j = 1; j <= QB; j++) begin
				rem_s[j] <= rem_nxt[j];
				d_s[j] <= d_s[j-1];
				q_s[j] <= q_nxt[j];
				ovf_s[j] <= ovf_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign out_vld = vld_s[QB];
	assign out_res.q = q_s[QB];
	assign out_res.ovf = ovf_s[QB];
	assign out_side = side_s[QB];

endmodule

>>> rtl/core/tpc_minnaert.sv
`timescale 1ns / 1ps

module tpc_minnaert (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [14:0] cos_zenith,
	input logic [15:0] minnaert_k,
	input logic in_vld,
	input tpc_pkg::tpc_side_t in_side,
	input tpc_pkg::tpc_div_t in_div,
	output logic out_vld,
	output tpc_pkg::tpc_side_t out_side,
	output tpc_pkg::tpc_div_t out_div,
	output tpc_pkg::tpc_mres_t out_mres
);

	localparam int LB = tpc_pkg::LUT_BITS;
	localparam int LSH = tpc_pkg::LOG_SH;
	localparam int ESH = tpc_pkg::EXP_SH;
	localparam int NS = 7;

	function automatic logic [3:0] msb_pos(input logic [14:0] x);
		logic [3:0] p;
		p = '0;
		for (int i = 0; i < 15; i++) begin
			if (x[i]) begin
				p = 4'(i);
			end
		end
		return p;
	endfunction

	function automatic logic [20:0] log_interp(input logic [3:0] e, input logic [LB-1:0] idx,
			input logic [LSH-1:0] fr);
		logic [LB:0] ix;
		logic [16:0] lo;
		logic [16:0] hi;
		logic [16:0] d;
		logic [31:0] prod;
		ix = {1'b0, idx};
		lo = tpc_pkg::LOG_TAB[ix];
		hi = tpc_pkg::LOG_TAB[ix + 1'b1];
		d = hi - lo;
		prod = 32'(d) * 32'(fr) + (32'd1 << (LSH - 1));
		return 21'({e, 16'b0}) + 21'(lo) + 21'(prod >> LSH);
	endfunction

	logic [NS:1] vld_s;
	tpc_pkg::tpc_side_t side_s [1:NS];
	tpc_pkg::tpc_div_t div_s [1:NS];

	logic [3:0] ez_s1, ei_s1;
	logic [LB-1:0] idxz_s1, idxi_s1;
	logic [LSH-1:0] frz_s1, fri_s1;
	logic [20:0] lz_s2, li_s2;
	logic [36:0] magk_s3;
	logic lneg_s3;
	logic signed [11:0] sh_s4;
	logic [LB-1:0] idxe_s4;
	logic [ESH-1:0] fre_s4;
	logic signed [11:0] sh_s5;
	logic [17:0] e2_s5;
	logic signed [11:0] sh_s6;
	logic [33:0] p_s6;
	tpc_pkg::tpc_mres_t mres_s7;

	logic [3:0] ez, ei;
	logic [15:0] nz, ni;
	logic signed [21:0] lr;
	logic [20:0] lmag;
	logic [25:0] tm;
	logic [26:0] tt;
	logic signed [11:0] sh;
	logic [LB:0] ixe;
	logic [17:0] elo, ehi, ed;
	logic [31:0] eprod;
	logic [17:0] e2;
	logic big;
	logic [49:0] r;
	logic [5:0] shr;
	logic [34:0] rnd;
	tpc_pkg::tpc_mres_t mres;

	always_comb begin
		ez = msb_pos(cos_zenith);
		ei = msb_pos(in_side.ci);
		nz = 16'({1'b0, cos_zenith} << (5'd15 - 5'(ez)));
		ni = 16'({1'b0, in_side.ci} << (5'd15 - 5'(ei)));
	end

	always_comb begin
		lr = $signed({1'b0, lz_s2}) - $signed({1'b0, li_s2});
		lmag = lr[21] ? 21'(-lr) : lr[20:0];
	end

	always_comb begin
		tm = 26'((magk_s3 + 37'd2048) >> 12);
		tt = lneg_s3 ? (27'd1 << 24) - 27'(tm) : (27'd1 << 24) + 27'(tm);
		sh = $signed({1'b0, tt[26:16]}) - 12'sd264;
	end

	always_comb begin
		ixe = {1'b0, idxe_s4};
		elo = tpc_pkg::EXP_TAB[ixe];
		ehi = tpc_pkg::EXP_TAB[ixe + 1'b1];
		ed = ehi - elo;
		eprod = 32'(ed) * 32'(fre_s4) + (32'd1 << (ESH - 1));
		e2 = elo + 18'(eprod >> ESH);
	end

	always_comb begin
		big = 1'b0;
		r = '0;
		shr = '0;
		rnd = '0;
		if (sh_s6 >= 12'sd16) begin
			big = 1'b1;
		end else if (sh_s6 >= 12'sd0) begin
			r = 50'(p_s6) << sh_s6[3:0];
		end else if (sh_s6 > -12'sd40) begin
			shr = 6'(-sh_s6);
			rnd = 35'(p_s6) + (35'd1 << (shr - 6'd1));
			r = 50'(rnd >> shr);
		end
		if (cos_zenith == 15'd0) begin
			big = 1'b0;
			r = (minnaert_k == 16'd0) ? (50'(side_s[6].v) << 8) : '0;
		end
		mres.sat = big || (r[49:31] != '0);
		mres.val = r[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-1:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= in_side;
			div_s[1] <= in_div;
			for (int j = 2; j <= NS; j++) begin
				side_s[j] <= side_s[j-1];
				div_s[j] <= div_s[j-1];
			end
			ez_s1 <= ez;
			ei_s1 <= ei;
			idxz_s1 <= nz[14:LSH];
			idxi_s1 <= ni[14:LSH];
			frz_s1 <= nz[LSH-1:0];
			fri_s1 <= ni[LSH-1:0];
			lz_s2 <= log_interp(ez_s1, idxz_s1, frz_s1);
			li_s2 <= log_interp(ei_s1, idxi_s1, fri_s1);
			magk_s3 <= 37'(lmag) * 37'(minnaert_k);
			lneg_s3 <= lr[21];
			sh_s4 <= sh;
			idxe_s4 <= tt[15:ESH];
			fre_s4 <= tt[ESH-1:0];
			sh_s5 <= sh_s4;
			e2_s5 <= e2;
			sh_s6 <= sh_s5;
			p_s6 <= 34'(side_s[5].v) * 34'(e2_s5);
			mres_s7 <= mres;
		end
	end

	assign out_vld = vld_s[NS];
	assign out_side = side_s[NS];
	assign out_div = div_s[NS];
	assign out_mres = mres_s7;

endmodule

>>> rtl/core/topographic_pixel_correction.sv
`timescale 1ns / 1ps

// Terrain illumination correction of one radiance sample per transaction in cosine,
// c-correction or Minnaert mode, with a signed Q24.8 result and a status code. The block
// takes one sample every cycle while its output buffer has room or its output is taken;
// a sample passes the input registers, the 33-stage restoring divider (an overflow check in
// its first stage, then one quotient bit per stage) and the seven-stage log2/exp2 Minnaert
// pipeline to reach the output buffer. A two-entry buffer lets new samples enter while a
// result waits. Configuration registers must be written only while the block is idle.
module topographic_pixel_correction (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input tpc_pkg::tpc_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output tpc_pkg::tpc_out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);

	logic [1:0] mode_q;
	logic [14:0] cos_zenith_q;
	logic signed [31:0] c_term_q;
	logic [15:0] minnaert_k_q;

	logic en;
	logic push;
	logic pop;
	logic [1:0] cnt_q;
	logic wr_ptr_q;
	logic rd_ptr_q;
	tpc_pkg::tpc_out_t fifo_q [2];

	logic ccorr;
	logic minn;
	logic signed [33:0] num;
	logic signed [33:0] den;
	logic signed [50:0] prod;
	logic [1:0] st;
	tpc_pkg::tpc_side_t side1;

	logic vld_s1;
	logic signed [50:0] prod_s1;
	logic [32:0] den_s1;
	tpc_pkg::tpc_side_t side_s1;

	logic [49:0] mag;
	tpc_pkg::tpc_side_t side2;
	logic vld_s2;
	logic [tpc_pkg::N_W-1:0] num_s2;
	logic [tpc_pkg::D_W-1:0] den_s2;
	tpc_pkg::tpc_side_t side_s2;

	logic div_vld;
	tpc_pkg::tpc_div_t div_res;
	tpc_pkg::tpc_side_t div_side;

	logic mn_vld;
	tpc_pkg::tpc_side_t mn_side;
	tpc_pkg::tpc_div_t mn_div;
	tpc_pkg::tpc_mres_t mn_res;

	tpc_pkg::tpc_out_t result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
			cos_zenith_q <= 15'd32767;
			c_term_q <= '0;
			minnaert_k_q <= 16'd4096;
		end else if (cfg_valid) begin
			unique case (tpc_pkg::tpc_reg_e'(cfg_index))
				tpc_pkg::REG_MODE: mode_q <= cfg_data[1:0];
				tpc_pkg::REG_COS_ZENITH: cos_zenith_q <= cfg_data[14:0];
				tpc_pkg::REG_C_TERM: c_term_q <= $signed(cfg_data);
				tpc_pkg::REG_MINNAERT_K: minnaert_k_q <= cfg_data[15:0];
			endcase
		end
	end

	assign en = (cnt_q != 2'd2) || out_ready;
	assign in_ready = en;

	always_comb begin
		ccorr = mode_q == tpc_pkg::MODE_CCORR;
		minn = mode_q == tpc_pkg::MODE_MINN;
		if (ccorr) begin
			num = $signed({18'b0, cos_zenith_q, 1'b0}) + 34'(c_term_q);
			den = $signed({{17{in_data.cos_illum[15]}}, in_data.cos_illum, 1'b0}) + 34'(c_term_q);
		end else begin
			num = $signed({19'b0, cos_zenith_q});
			den = 34'(in_data.cos_illum);
		end
		prod = $signed({1'b0, in_data.sample_value}) * num;
		if (!in_data.sample_valid) begin
			st = tpc_pkg::ST_INVALID;
		end else if (ccorr) begin
			st = (den <= 34'sd0) ? tpc_pkg::ST_SHADOW : tpc_pkg::ST_OK;
		end else if (in_data.cos_illum <= 16'sd0) begin
			st = tpc_pkg::ST_SHADOW;
		end else if (minn && in_data.sample_value == 16'd0) begin
			st = tpc_pkg::ST_INVALID;
		end else begin
			st = tpc_pkg::ST_OK;
		end
		side1.v = in_data.sample_value;
		side1.ci = in_data.cos_illum[14:0];
		side1.status = st;
		side1.minn = minn;
		side1.neg = 1'b0;
	end

	always_comb begin
		mag = prod_s1[50] ? 50'(-prod_s1) : prod_s1[49:0];
		side2 = side_s1;
		side2.neg = prod_s1[50];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			den_s1 <= (st == tpc_pkg::ST_OK) ? den[32:0] : 33'd1;
			side_s1 <= side1;
			num_s2 <= {mag[48:0], 9'b0} + tpc_pkg::N_W'(den_s1);
			den_s2 <= {den_s1, 1'b0};
			side_s2 <= side2;
		end
	end

	tpc_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s2),
		.in_num(num_s2),
		.in_den(den_s2),
		.in_side(side_s2),
		.out_vld(div_vld),
		.out_res(div_res),
		.out_side(div_side)
	);

	tpc_minnaert u_mn (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.cos_zenith(cos_zenith_q),
		.minnaert_k(minnaert_k_q),
		.in_vld(div_vld),
		.in_side(div_side),
		.in_div(div_res),
		.out_vld(mn_vld),
		.out_side(mn_side),
		.out_div(mn_div),
		.out_mres(mn_res)
	);

	always_comb begin
		result.corrected = '0;
		result.status = mn_side.status;
		if (mn_side.status == tpc_pkg::ST_OK) begin
			if (mn_side.minn) begin
				if (mn_res.sat) begin
					result.corrected = 32'sh7fffffff;
					result.status = tpc_pkg::ST_SAT;
				end else begin
					result.corrected = $signed({1'b0, mn_res.val});
				end
			end else if (mn_side.neg) begin
				if (mn_div.ovf || mn_div.q > 32'h80000000) begin
					result.corrected = 32'sh80000000;
					result.status = tpc_pkg::ST_SAT;
				end else begin
					result.corrected = $signed(32'd0 - mn_div.q);
				end
			end else begin
				if (mn_div.ovf || mn_div.q[31]) begin
					result.corrected = 32'sh7fffffff;
					result.status = tpc_pkg::ST_SAT;
				end else begin
					result.corrected = $signed(mn_div.q);
				end
			end
		end
	end

	assign push = mn_vld && en;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= result;
		end
	end

	assign out_valid = cnt_q != 2'd0;
	assign out_data = fifo_q[rd_ptr_q];

endmodule

>>> rtl/core/tpc_checker.sv
`timescale 1ns / 1ps
`include "topographic_pixel_correction_defines.svh"

module tpc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input tpc_pkg::tpc_out_t out_data
);

	logic bad_st;
	logic sat_st;
	logic at_bound;
	logic out_stall;
	logic [31:0] res;

	assign res = out_data.corrected;
	assign bad_st = out_valid && (out_data.status == tpc_pkg::ST_INVALID ||
		out_data.status == tpc_pkg::ST_SHADOW);
	assign sat_st = out_valid && out_data.status == tpc_pkg::ST_SAT;
	assign at_bound = res == 32'h7fffffff || res == 32'h80000000;
	assign out_stall = out_valid && !out_ready;

	`TPC_ASSERT_NOW(a_zero_on_error, bad_st, res == 32'd0, "Error status with a nonzero result.")
	`TPC_ASSERT_NOW(a_sat_bound, sat_st, at_bound, "Saturated result not at a bound.")
	`TPC_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "Input stalled while empty.")
	`TPC_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "Stalled result changed.")

endmodule

bind topographic_pixel_correction tpc_checker u_tpc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
